@@ sv/ura_pkg.sv @@
`default_nettype none
package ura_pkg;

  localparam int VALUE_W = 16;
  localparam int RADIX_W = 6;
  localparam int CHAR_W = 7;
  localparam int DEFAULT_MAX_DIGITS = 6;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // quotient bits resolved per divider cycle
  localparam int STEP_BITS = 2;
  localparam int DIV_STEPS = VALUE_W / STEP_BITS;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] DECIMAL_TEN = 7'h0a;

  // one queued word: value plus the base it is converted in
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] base;
  } ura_item_t;

  // clamp a raw radix into 2..36
  function automatic logic [RADIX_W-1:0] radix_clamp(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) return RADIX_MIN;
    if (r > RADIX_MAX) return RADIX_MAX;
    return r;
  endfunction

  // digit value to ascii, 0-9 then A onward
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (dx < DECIMAL_TEN) return CHAR_ZERO + dx;
    return CHAR_UPPER_A + (dx - DECIMAL_TEN);
  endfunction

endpackage
`default_nettype wire

@@ sv/ura_front.sv @@
`default_nettype none
module ura_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          radix_we,
  input  logic [ura_pkg::RADIX_W-1:0]   radix_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ura_pkg::VALUE_W-1:0]   value,
  input  logic                          queue_full,
  output logic                          push,
  output ura_pkg::ura_item_t            push_item
);
  import ura_pkg::*;

  logic [RADIX_W-1:0] radix;

  // radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  // accept a word whenever the queue has room, tagging it with the clamped base
  assign in_stall = queue_full;
  assign push = in_valid && !queue_full;
  assign push_item.value = value;
  assign push_item.base = radix_clamp(radix);

endmodule
`default_nettype wire

@@ sv/ura_fifo.sv @@
`default_nettype none
module ura_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ura_pkg::ura_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output ura_pkg::ura_item_t pop_item
);
  import ura_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ura_item_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/ura_back.sv @@
`default_nettype none
module ura_back #(
  parameter int MAX_DIGITS = ura_pkg::DEFAULT_MAX_DIGITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          not_empty,
  input  ura_pkg::ura_item_t            pop_item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ura_pkg::CHAR_W-1:0]    digit_char,
  output logic                          last_digit,
  output logic                          too_long
);
  import ura_pkg::*;

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int NDIG_W = $clog2(MAX_DIGITS + 1);
  localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t              state;
  logic [VALUE_W-1:0]  quot;
  logic [RADIX_W-1:0]  rem;
  logic [RADIX_W-1:0]  base;
  logic [STEP_W-1:0]   step;
  logic [NDIG_W-1:0]   ndig;
  logic [IDX_W-1:0]    ptr;
  logic                ovf;
  logic [RADIX_W-1:0]  digs [MAX_DIGITS];

  logic [VALUE_W-1:0]  quot_next;
  logic [RADIX_W-1:0]  rem_next;
  logic [RADIX_W:0]    trial;
  logic                slot_free;

  assign pop = (state == S_IDLE) && not_empty;
  assign slot_free = !out_valid || !out_stall;

  // restoring divide, STEP_BITS quotient bits per cycle
  always_comb begin
    quot_next = quot;
    rem_next = rem;
    trial = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem_next, quot_next[VALUE_W-1]};
      quot_next = {quot_next[VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, base}) begin
        trial = trial - {1'b0, base};
        quot_next[0] = 1'b1;
      end
      rem_next = trial[RADIX_W-1:0];
    end
  end

  // sequencer: divide out digits low first, then play them back high first, or give one too_long word on overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      step <= '0;
      ndig <= '0;
      ptr <= '0;
      ovf <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid <= (state == S_EMIT);
      end
      case (state)
        S_IDLE: begin
          if (not_empty) begin
            quot <= pop_item.value;
            base <= pop_item.base;
            rem <= '0;
            step <= '0;
            ndig <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          quot <= quot_next;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            step <= '0;
            rem <= '0;
            digs[ndig[IDX_W-1:0]] <= rem_next;
            if (quot_next == '0) begin
              ptr <= ndig[IDX_W-1:0];
              ovf <= 1'b0;
              state <= S_EMIT;
            end else if (ndig == NDIG_W'(MAX_DIGITS - 1)) begin
              ovf <= 1'b1;
              state <= S_EMIT;
            end else begin
              ndig <= ndig + 1'b1;
            end
          end else begin
            step <= step + 1'b1;
            rem <= rem_next;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            if (ovf) begin
              digit_char <= '0;
              last_digit <= 1'b1;
              too_long <= 1'b1;
              state <= S_IDLE;
            end else begin
              digit_char <= digit_ascii(digs[ptr]);
              last_digit <= (ptr == '0);
              too_long <= 1'b0;
              if (ptr == '0) begin
                state <= S_IDLE;
              end else begin
                ptr <= ptr - 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("back state not one-hot");

  a_overflow_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_long |-> last_digit && (digit_char == '0))
    else $error("overflow word malformed");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> ndig < NDIG_W'(MAX_DIGITS))
    else $error("digit count beyond limit");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == S_DIV)
    else $error("dequeue did not start a division");

endmodule
`default_nettype wire

@@ sv/unsigned_to_radix_ascii_top.sv @@
// Converts each accepted 16-bit unsigned value into ASCII digits in the base held in
// the radix register (reset 10, values below 2 act as 2 and above 36 act as 36), most
// significant digit first, with last_digit set on the final character; a value that
// needs more than MAX_DIGITS digits gives one word with too_long set and digit_char 0.
// A shared restoring divider peels off one digit per pass over the 16-bit quotient (two
// quotient bits per cycle); all digits of a value are divided out before the first is
// output, and the next value is only dequeued once the last word has been issued.
// A two-entry queue lets new values be taken in while the divider is busy and while
// output words are stalled.
`default_nettype none
module unsigned_to_radix_ascii_top #(
  parameter int MAX_DIGITS = ura_pkg::DEFAULT_MAX_DIGITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          radix_we,
  input  logic [ura_pkg::RADIX_W-1:0]   radix_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ura_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ura_pkg::CHAR_W-1:0]    digit_char,
  output logic                          last_digit,
  output logic                          too_long
);
  import ura_pkg::*;

  logic      push;
  ura_item_t push_item;
  logic      queue_full;
  logic      pop;
  logic      not_empty;
  ura_item_t pop_item;

  // accept and tag with base
  ura_front u_front (
    .clk         (clk),
    .rst         (rst),
    .radix_we    (radix_we),
    .radix_wdata (radix_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .queue_full  (queue_full),
    .push        (push),
    .push_item   (push_item)
  );

  // decoupling queue
  ura_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_item  (pop_item)
  );

  // divide and emit
  ura_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (not_empty),
    .pop_item   (pop_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last_digit (last_digit),
    .too_long   (too_long)
  );

endmodule
`default_nettype wire

@@ dv/ura_checker.sv @@
`timescale 1ns / 100ps
module ura_checker #(
  parameter int MAX_DIGITS = ura_pkg::DEFAULT_MAX_DIGITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        radix_we,
  input  logic [ura_pkg::RADIX_W-1:0] radix_wdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [ura_pkg::VALUE_W-1:0] value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [ura_pkg::CHAR_W-1:0]  digit_char,
  input  logic                        last_digit,
  input  logic                        too_long,
  output int                          errors,
  output int                          pending
);
  import ura_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              too_long;
  } digit_word_t;

  logic [RADIX_W-1:0] radix_copy = RADIX_RESET;
  digit_word_t        expected_chars[$];

  // convert one value in the current base and queue the words it should give
  task automatic predict_digits(input logic [VALUE_W-1:0] v);
    logic [RADIX_W-1:0] base;
    logic [VALUE_W-1:0] rest;
    logic [RADIX_W-1:0] digs[16];
    int                 n;
    digit_word_t        w;
    base = radix_copy;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    rest = v;
    n = 0;
    do begin
      digs[n] = RADIX_W'(rest % base);
      n++;
      rest = rest / base;
    end while (rest != 0 && n < MAX_DIGITS);
    if (rest != 0) begin
      // does not fit: single flagged word
      w.ch = '0;
      w.last = 1'b1;
      w.too_long = 1'b1;
      expected_chars.push_back(w);
    end else begin
      for (int k = 0; k < n; k++) begin
        if (digs[n-1-k] < 10) w.ch = CHAR_ZERO + CHAR_W'(digs[n-1-k]);
        else w.ch = CHAR_UPPER_A + CHAR_W'(digs[n-1-k] - 6'd10);
        w.last = (k == n - 1);
        w.too_long = 1'b0;
        expected_chars.push_back(w);
      end
    end
  endtask

  // log a bad word; only the first few are printed
  task automatic flag_word(input string what, input digit_word_t want);
    errors++;
    if (errors <= 10)
      $display("%0t: %s: expected char %h last %b too_long %b, got char %h last %b too_long %b",
               $realtime, what, want.ch, want.last, want.too_long,
               digit_char, last_digit, too_long);
  endtask

  // follow config writes, predict accepted values, compare accepted words
  always @(posedge clk) begin
    digit_word_t want;
    if (rst) begin
      radix_copy = RADIX_RESET;
      expected_chars.delete();
    end else begin
      if (radix_we) radix_copy = radix_wdata;
      if (in_valid && !in_stall) predict_digits(value);
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          want = '0;
          flag_word("unexpected word", want);
        end else begin
          want = expected_chars.pop_front();
          if (digit_char !== want.ch || last_digit !== want.last ||
              too_long !== want.too_long)
            flag_word("word mismatch", want);
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
  import ura_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               radix_we = 1'b0;
  logic [RADIX_W-1:0] radix_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  digit_char;
  logic               last_digit;
  logic               too_long;
  int                 errors;
  int                 pending;

  // receiver hold-off request and its completion
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;
  int burst_left = 0;
  int cur_base = 10;

  always #1 clk = ~clk;

  unsigned_to_radix_ascii_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .radix_we   (radix_we),
    .radix_wdata(radix_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last_digit (last_digit),
    .too_long   (too_long)
  );

  ura_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .radix_we   (radix_we),
    .radix_wdata(radix_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last_digit (last_digit),
    .too_long   (too_long),
    .errors     (errors),
    .pending    (pending)
  );

  // offer one value, in bursts with random gaps unless told to push hard
  task automatic offer_value(input logic [VALUE_W-1:0] v, input bit no_gap = 1'b0);
    int gap;
    if (!no_gap && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  // stop offering and wait until every expected word has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] r);
    wait_idle();
    radix_we <= 1'b1;
    radix_wdata <= r;
    cur_base = (r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r;
    @(posedge clk);
    radix_we <= 1'b0;
  endtask

  // random value with a spread of digit counts, sometimes on a digit-count boundary
  function automatic logic [VALUE_W-1:0] pick_value();
    longint pw;
    if ($urandom_range(0, 7) == 0) begin
      pw = 1;
      repeat ($urandom_range(1, 6)) pw *= cur_base;
      if (pw > 65535) return '1;
      return VALUE_W'(pw - $urandom_range(0, 1));
    end
    return VALUE_W'($urandom) >> $urandom_range(0, 15);
  endfunction

  // receiver stall pattern, changing every stretch, plus one long hold-off
  initial begin
    int mode;
    int span;
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int n = 0; n < span; n++) begin
        if (hold_off_req && !hold_off_done) begin
          out_stall <= 1'b1;
          repeat (400) @(posedge clk);
          hold_off_done = 1'b1;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (n % 4 == 3);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset base ten: zero, one digit, widest value
    offer_value(16'd0);
    offer_value(16'd9);
    offer_value(16'd65535);
    // top base: highest letter digit, carry into two digits
    set_radix(6'd36);
    offer_value(16'd35);
    offer_value(16'd36);
    offer_value(16'd65535);
    offer_value(16'd0);
    // base two: six ones fit, one more overflows
    set_radix(6'd2);
    offer_value(16'd63);
    offer_value(16'd64);
    offer_value(16'd1);
    // bases below two act as two
    set_radix(6'd0);
    offer_value(16'd63);
    offer_value(16'd64);
    set_radix(6'd1);
    offer_value(16'd2);
    // bases above thirty-six act as thirty-six
    set_radix(6'd63);
    offer_value(16'd35);
    offer_value(16'd1295);
    set_radix(6'd37);
    offer_value(16'd46655);
    // base six: largest six-digit value and the first overflow
    set_radix(6'd6);
    offer_value(16'd46655);
    offer_value(16'd46656);
    set_radix(6'd16);
    offer_value(16'hABCD);

    // long receiver hold-off while values keep coming
    set_radix(6'($urandom_range(2, 36)));
    hold_off_req = 1'b1;
    for (int i = 0; i < 45; i++) offer_value(pick_value(), 1'b1);

    // random phases, each in a new base
    for (int p = 0; p < 9; p++) begin
      if ($urandom_range(0, 3) == 0) set_radix(6'($urandom_range(2, 6)));
      else set_radix(6'($urandom_range(0, 63)));
      for (int i = 0; i < 45; i++) offer_value(pick_value());
    end

    wait_idle();
    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
